>>> rtl/core/kred_pkg.sv
package kred_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int EVENTS    = 2 * KEY_SLOTS;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;
  localparam int SLOT_BASE  = 15;

  localparam logic [6:0] MIN_REPORT_LEN = 7'd8;
  localparam logic [7:0] LAST_NO_KEY    = 8'd3;

  typedef logic [7:0] usage_t;

  typedef struct packed {
    logic rel;
    logic prs;
  } lane_hit_t;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic sup;
  } mods_t;

  function automatic logic is_mapped(input usage_t u);
    logic hit;
    hit = ((u >= 8'h04) && (u <= 8'h31)) || ((u >= 8'h33) && (u <= 8'h38));
    return hit;
  endfunction

endpackage

>>> rtl/core/keyboard_report_key_event_diff.sv
// Channel | Dir | Ports                        | Beat
// in      | in  | in_tvalid/in_tready/in_tdata | one boot keyboard report
// out     | out | out_tvalid/out_tready/out_*  | one key event, tlast on the report's last
//
// A report is compared against the stored slots in the cycle it is accepted,
// by one lane per slot; the merge stage then sends its events one per cycle
// while out_tready is high. A report's events occupy the event queue until each
// has moved to the output register, where an event waits while out_tready is low.
// The next report is taken in the cycle the last event moves to the output register.
// Short reports and reports with no change do not occupy the event queue.
// Reset (rst_n low, synchronous) clears the stored slots and empties the queue.
module keyboard_report_key_event_diff
  import kred_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [6:0] report_length, [14:7] modifier_bits, [22:15] key_slot_0,
  // [30:23] key_slot_1, [38:31] key_slot_2, [46:39] key_slot_3,
  // [54:47] key_slot_4, [62:55] key_slot_5, [63] zero
  input  logic [IN_DATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] usage_code, [8] released, [9] shift_held, [10] ctrl_held,
  // [11] super_held, [12] mapped, [15:13] zero
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tlast
);

  usage_t [KEY_SLOTS-1:0]  prev_r, prev_nxt;
  usage_t [KEY_SLOTS-1:0]  fresh;
  lane_hit_t [KEY_SLOTS-1:0] hits;
  logic [EVENTS-1:0]       ev_mask;
  usage_t [EVENTS-1:0]     ev_codes;
  mods_t                   mods;
  logic [6:0]              rep_len;
  logic [7:0]              mod_bits;
  logic                    accept;
  logic                    long_rep;
  logic                    load;
  logic                    can_load;

  always_comb begin
    rep_len  = in_tdata[6:0];
    mod_bits = in_tdata[14:7];
    for (int i = 0; i < KEY_SLOTS; i++) begin
      fresh[i] = in_tdata[SLOT_BASE + 8*i +: 8];
    end
    mods.ctrl  = mod_bits[0] | mod_bits[4];
    mods.shift = mod_bits[1] | mod_bits[5];
    mods.sup   = mod_bits[3] | mod_bits[7];
  end

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    kred_lane u_lane (
      .old_code    (prev_r[g]),
      .new_code    (fresh[g]),
      .prev_slots  (prev_r),
      .fresh_slots (fresh),
      .hit         (hits[g])
    );
  end

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      ev_mask[2*i]    = hits[i].rel;
      ev_mask[2*i+1]  = hits[i].prs;
      ev_codes[2*i]   = prev_r[i];
      ev_codes[2*i+1] = fresh[i];
    end
  end

  assign in_tready = can_load;
  assign accept    = in_tvalid && in_tready;
  assign long_rep  = (rep_len >= MIN_REPORT_LEN);
  assign load      = accept && long_rep;
  assign prev_nxt  = load ? fresh : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

  kred_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_mask  (ev_mask),
    .load_codes (ev_codes),
    .load_mods  (mods),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_store_on_long: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (prev_r == $past(fresh)))
    else $error("stored slots not replaced by accepted report");

  a_hold_on_short: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !long_rep) |=> $stable(prev_r))
    else $error("short report changed stored slots");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("event queue not empty after reset");
`endif

endmodule

>>> rtl/core/kred_lane.sv
module kred_lane
  import kred_pkg::*;
(
  input  usage_t                    old_code,
  input  usage_t                    new_code,
  input  usage_t [KEY_SLOTS-1:0]    prev_slots,
  input  usage_t [KEY_SLOTS-1:0]    fresh_slots,
  output lane_hit_t                 hit
);

  logic old_seen;
  logic new_seen;

  always_comb begin
    old_seen = 1'b0;
    new_seen = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (fresh_slots[k] == old_code) old_seen = 1'b1;
      if (prev_slots[k] == new_code) new_seen = 1'b1;
    end
    hit.rel = (old_code > LAST_NO_KEY) && !old_seen;
    hit.prs = (new_code > LAST_NO_KEY) && !new_seen;
  end

endmodule

>>> rtl/core/kred_merge.sv
module kred_merge
  import kred_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic [EVENTS-1:0]        load_mask,
  input  usage_t [EVENTS-1:0]      load_codes,
  input  mods_t                    load_mods,
  output logic                     can_load,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_W-1:0]    out_tdata,
  output logic                     out_tlast
);

  logic [EVENTS-1:0]     pend_r, pend_nxt;
  usage_t [EVENTS-1:0]   codes_r;
  mods_t                 mods_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic [EVENTS-1:0]     lowbit;
  logic [EVENTS-1:0]     rest;
  logic                  emit;
  usage_t                sel_code;
  logic                  sel_rel;
  logic [OUT_DATA_W-1:0] sel_data;

  always_comb begin
    lowbit   = pend_r & (~pend_r + {{(EVENTS-1){1'b0}}, 1'b1});
    rest     = pend_r & ~lowbit;
    emit     = (pend_r != '0) && (!out_valid_r || out_tready);
    can_load = (pend_r == '0) || (emit && (rest == '0));

    sel_code = '0;
    sel_rel  = 1'b0;
    for (int k = 0; k < EVENTS; k++) begin
      if (lowbit[k]) begin
        sel_code = sel_code | codes_r[k];
        // even positions are releases, odd ones presses
        sel_rel  = sel_rel | ((k % 2) == 0);
      end
    end

    sel_data       = '0;
    sel_data[7:0]  = sel_code;
    sel_data[8]    = sel_rel;
    sel_data[9]    = !sel_rel && mods_r.shift;
    sel_data[10]   = !sel_rel && mods_r.ctrl;
    sel_data[11]   = !sel_rel && mods_r.sup;
    sel_data[12]   = is_mapped(sel_code);

    if (load) begin
      pend_nxt = load_mask;
    end else if (emit) begin
      pend_nxt = rest;
    end else begin
      pend_nxt = pend_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      codes_r <= load_codes;
      mods_r  <= load_mods;
    end
    if (emit) begin
      out_data_r <= sel_data;
      out_last_r <= (rest == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> verif/tb_keyboard_report_key_event_diff.sv
module tb_keyboard_report_key_event_diff;
  timeunit 1ns;
  timeprecision 1ps;
  import kred_pkg::*;

  localparam int RANDOM_REPORTS = 330;
  localparam int DRAIN_CYCLES   = 2 * EVENTS + 16;

  typedef struct packed {
    usage_t usage;
    logic   released;
    logic   shift;
    logic   ctrl;
    logic   sup;
    logic   mapped;
    logic   last;
  } kbd_evt_t;

  typedef struct {
    logic [IN_DATA_W-1:0] data;
    bit                   steady;
  } report_beat_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  report_beat_t report_q[$];
  kbd_evt_t     evt_q[$];
  usage_t       held_slots[KEY_SLOTS];

  int reports_queued  = 0;
  int reports_taken   = 0;
  int short_reports   = 0;
  int events_checked  = 0;
  int mismatches      = 0;
  int gap_left        = 0;
  int stall_left      = 0;
  int calm_left       = 0;

  keyboard_report_key_event_diff DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(8_000_000);
    $display("timeout: %0d of %0d reports taken, %0d events pending",
             reports_taken, reports_queued, evt_q.size());
    $display("tb_keyboard_report_key_event_diff: errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic bit slot_holds(input usage_t s[KEY_SLOTS], input usage_t u);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++)
      if (s[i] == u) hit = 1'b1;
    return hit;
  endfunction

  function automatic kbd_evt_t make_evt(input usage_t u, input logic rel,
                                        input mods_t m);
    kbd_evt_t ev;
    ev.usage    = u;
    ev.released = rel;
    ev.shift    = rel ? 1'b0 : m.shift;
    ev.ctrl     = rel ? 1'b0 : m.ctrl;
    ev.sup      = rel ? 1'b0 : m.sup;
    ev.mapped   = (u inside {[8'h04:8'h31], [8'h33:8'h38]});
    ev.last     = 1'b0;
    return ev;
  endfunction

  // Diff one accepted report against the held slots and queue its key events.
  function automatic void diff_report(input logic [IN_DATA_W-1:0] d);
    logic [6:0]  len;
    logic [7:0]  mods;
    mods_t       m;
    usage_t      fresh[KEY_SLOTS];
    kbd_evt_t    evs[$];
    usage_t      old_u;
    usage_t      new_u;
    len  = d[6:0];
    mods = d[14:7];
    if (len < MIN_REPORT_LEN) begin
      short_reports++;
      return;
    end
    for (int i = 0; i < KEY_SLOTS; i++)
      fresh[i] = d[SLOT_BASE + 8 * i +: 8];
    m.ctrl  = mods[0] | mods[4];
    m.shift = mods[1] | mods[5];
    m.sup   = mods[3] | mods[7];
    for (int i = 0; i < KEY_SLOTS; i++) begin
      old_u = held_slots[i];
      new_u = fresh[i];
      if (old_u > LAST_NO_KEY && !slot_holds(fresh, old_u))
        evs.push_back(make_evt(old_u, 1'b1, m));
      if (new_u > LAST_NO_KEY && !slot_holds(held_slots, new_u))
        evs.push_back(make_evt(new_u, 1'b0, m));
    end
    held_slots = fresh;
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) evt_q.push_back(evs[i]);
  endfunction

  always @(posedge clk) begin
    report_beat_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      gap_left  <= 0;
      foreach (held_slots[i]) held_slots[i] = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        diff_report(in_tdata);
        reports_taken++;
      end
      // hold the beat until it is taken
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (report_q.size() > 0) begin
          nxt = report_q.pop_front();
          in_tdata  <= nxt.data;
          in_tvalid <= 1'b1;
          gap_left  <= (nxt.steady || $urandom_range(0, 1)) ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      calm_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left  <= calm_left - 1;
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        calm_left  <= $urandom_range(20, 80);
        out_tready <= 1'b1;
      end else if (r < 60) begin
        out_tready <= 1'b1;
      end else begin
        stall_left <= pick_gap() - 1;
        out_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    kbd_evt_t got;
    kbd_evt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.usage    = out_tdata[7:0];
      got.released = out_tdata[8];
      got.shift    = out_tdata[9];
      got.ctrl     = out_tdata[10];
      got.sup      = out_tdata[11];
      got.mapped   = out_tdata[12];
      got.last     = out_tlast;
      if (evt_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected event usage %h released %b last %b",
                   $realtime, got.usage, got.released, got.last);
        mismatches++;
      end else begin
        want = evt_q.pop_front();
        events_checked++;
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("%0t: event mismatch (exp/got) usage %h/%h released %b/%b",
                     $realtime, want.usage, got.usage, want.released, got.released);
            $display("  shift %b/%b ctrl %b/%b super %b/%b mapped %b/%b last %b/%b",
                     want.shift, got.shift, want.ctrl, got.ctrl, want.sup, got.sup,
                     want.mapped, got.mapped, want.last, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic queue_report(input int len, input logic [7:0] mods,
                              input usage_t k0, input usage_t k1, input usage_t k2,
                              input usage_t k3, input usage_t k4, input usage_t k5,
                              input bit steady);
    report_beat_t b;
    b.data        = '0;
    b.data[6:0]   = len[6:0];
    b.data[14:7]  = mods;
    b.data[SLOT_BASE +: 48] = {k5, k4, k3, k2, k1, k0};
    b.steady      = steady;
    report_q.push_back(b);
    reports_queued++;
  endtask

  function automatic usage_t rand_usage();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return usage_t'($urandom_range(0, 3));
    if (r < 3) return usage_t'($urandom_range(0, 255));
    return usage_t'($urandom_range(8'h04, 8'h38));
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, 7);
    if (r < 20) return $urandom_range(9, 64);
    return 8;
  endfunction

  initial begin
    usage_t keys[KEY_SLOTS];
    usage_t spare;
    int     idx;
    int     len;
    int     r;
    int     p;
    bit     steady;

    // directed: empty report, presses, short drops, full swap, reorder,
    // no-key codes, range edges, repeats, modifier bits one by one
    queue_report(8,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_report(8,  8'h01, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 1'b0);
    queue_report(7,  8'h02, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 1'b0);
    queue_report(0,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_report(64, 8'h22, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 1'b1);
    queue_report(8,  8'h10, 8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'h0A, 1'b0);
    queue_report(8,  8'h08, 8'h00, 8'h01, 8'h02, 8'h03, 8'h38, 8'h39, 1'b0);
    queue_report(8,  8'h80, 8'h31, 8'h32, 8'h33, 8'h04, 8'hFF, 8'h80, 1'b0);
    queue_report(9,  8'h04, 8'h20, 8'h20, 8'h20, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_report(8,  8'h40, 8'h20, 8'h00, 8'h20, 8'h03, 8'h20, 8'h00, 1'b0);
    queue_report(8,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_report(42, 8'hAA, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h01, 8'h40, 1'b1);
    queue_report(21, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_report(8,  8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37, 1'b0);
    queue_report(8,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37, 1'b0);

    // random: keys mostly evolve from the previous report, some noise
    foreach (keys[i]) keys[i] = '0;
    idx          = 0;
    steady       = 1'b0;
    while (reports_queued < RANDOM_REPORTS) begin
      if (idx % 20 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        foreach (keys[i]) keys[i] = usage_t'($urandom_range(0, 255));
      end else if (r < 16) begin
        spare = keys[0];
        for (int i = 0; i < KEY_SLOTS - 1; i++) keys[i] = keys[i + 1];
        keys[KEY_SLOTS - 1] = spare;
      end else begin
        foreach (keys[i]) begin
          p = $urandom_range(0, 99);
          if (p < 20) keys[i] = rand_usage();
          else if (p < 35) keys[i] = '0;
          else if (p < 40) keys[i] = keys[$urandom_range(0, KEY_SLOTS - 1)];
        end
      end
      len = rand_len();
      queue_report(len, 8'($urandom_range(0, 255)), keys[0], keys[1], keys[2],
                   keys[3], keys[4], keys[5], steady);
      idx++;
    end

    wait (rst_n);
    while (reports_taken != reports_queued) @(posedge clk);
    while (evt_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d reports (%0d short ones dropped), %0d key events checked",
             reports_taken, short_reports, events_checked);
    if (mismatches == 0) begin
      $display("tb_keyboard_report_key_event_diff: clean");
    end else begin
      $display("%0d failing events", mismatches);
      $display("tb_keyboard_report_key_event_diff: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/kred_pkg.sv
rtl/core/kred_lane.sv
rtl/core/kred_merge.sv
rtl/core/keyboard_report_key_event_diff.sv
verif/tb_keyboard_report_key_event_diff.sv
